@@ rtl/core/utv_pkg.sv @@
// shared constants and types for the upwind thickness voxel update
package utv_pkg;

  // configuration register format (unsigned Q8.8 millimetres)
  localparam int CFG_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam logic [CFG_BITS-1:0] VOXEL_SIZE_RESET = 16'd256;

  // default field widths
  localparam int GRAD_BITS_DEF   = 16;
  localparam int LEN_BITS_DEF    = 20;

  // width of the low part of the weight in the split weight times length multiply
  localparam int MUL_SPLIT       = 32;

  // number of register stages ahead of the divider chain
  localparam int FRONT_STAGES    = 6;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_VOXEL_SIZE_X = 2'd0,
    REG_VOXEL_SIZE_Y = 2'd1,
    REG_VOXEL_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic zero_weight;
    logic saturated;
  } div_flags_t;

endpackage

@@ rtl/core/upwind_thickness_voxel_update.sv @@
// top level of the upwind thickness voxel update
// Computes one voxel of an upwind path-length sweep: per axis the minus or
// plus neighbor length is chosen from the gradient sign (inverted on the
// reverse sweep), and new_length = (a*b*c + sum of w*L) / (sum of w) with
// w = (product of the other two voxel sizes) * |gradient component|, in
// Q12.8 truncated toward zero. A zero weight sum gives 0 with zero_weight,
// a quotient beyond LEN_BITS gives all ones with saturated. One voxel word
// is taken every cycle while no result is held back; each word passes the
// six-stage multiply and sum front end and then the divider chain, which
// resolves one quotient bit per cell. Stages that hold no word keep loading
// while a result waits, so bubbles close up under back pressure. Voxel
// sizes are written through the cfg port (index 0 x, 1 y, 2 z, others
// ignored) and must only change while no word is in flight; they reset to
// 1.0 mm. No clearing pass after reset.
module upwind_thickness_voxel_update #(
  parameter int GRAD_BITS = utv_pkg::GRAD_BITS_DEF,
  parameter int LEN_BITS  = utv_pkg::LEN_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [utv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [utv_pkg::CFG_BITS-1:0]         cfg_data,
  // voxel channel
  input  logic                                 vox_valid,
  output logic                                 vox_ready,
  input  logic                                 sweep_reverse,
  input  logic signed [GRAD_BITS-1:0]          grad_x,
  input  logic signed [GRAD_BITS-1:0]          grad_y,
  input  logic signed [GRAD_BITS-1:0]          grad_z,
  input  logic [LEN_BITS-1:0]                  len_x_minus,
  input  logic [LEN_BITS-1:0]                  len_x_plus,
  input  logic [LEN_BITS-1:0]                  len_y_minus,
  input  logic [LEN_BITS-1:0]                  len_y_plus,
  input  logic [LEN_BITS-1:0]                  len_z_minus,
  input  logic [LEN_BITS-1:0]                  len_z_plus,
  // result channel
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [LEN_BITS-1:0]                  new_length,
  output logic                                 zero_weight,
  output logic                                 saturated
);
  import utv_pkg::*;

  // weight sum width: two voxel sizes times a gradient magnitude, three terms
  localparam int DEN_BITS = 2 * CFG_BITS + GRAD_BITS + 1;

  // voxel size registers, always ready to take a write
  logic [CFG_BITS-1:0] size_x, size_y, size_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= VOXEL_SIZE_RESET;
      size_y <= VOXEL_SIZE_RESET;
      size_z <= VOXEL_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_VOXEL_SIZE_X: size_x <= cfg_data;
        REG_VOXEL_SIZE_Y: size_y <= cfg_data;
        REG_VOXEL_SIZE_Z: size_z <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // divider chain links; link 0 is the front end output
  logic                c_valid [0:LEN_BITS];
  logic                c_ready [0:LEN_BITS];
  logic [DEN_BITS-1:0] c_rem   [0:LEN_BITS];
  logic [DEN_BITS-1:0] c_den   [0:LEN_BITS];
  logic [LEN_BITS-1:0] c_low   [0:LEN_BITS];
  logic [LEN_BITS-1:0] c_q     [0:LEN_BITS];
  div_flags_t          c_flags [0:LEN_BITS];

  // front end: weights, numerator, weight sum, range check
  utv_front #(
    .GRAD_BITS (GRAD_BITS),
    .LEN_BITS  (LEN_BITS),
    .DEN_BITS  (DEN_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .size_x        (size_x),
    .size_y        (size_y),
    .size_z        (size_z),
    .up_valid      (vox_valid),
    .up_ready      (vox_ready),
    .sweep_reverse (sweep_reverse),
    .grad_x        (grad_x),
    .grad_y        (grad_y),
    .grad_z        (grad_z),
    .len_x_minus   (len_x_minus),
    .len_x_plus    (len_x_plus),
    .len_y_minus   (len_y_minus),
    .len_y_plus    (len_y_plus),
    .len_z_minus   (len_z_minus),
    .len_z_plus    (len_z_plus),
    .dn_valid      (c_valid[0]),
    .dn_ready      (c_ready[0]),
    .rem           (c_rem[0]),
    .den           (c_den[0]),
    .low           (c_low[0]),
    .flags         (c_flags[0])
  );

  // quotient starts empty and fills one bit per cell
  assign c_q[0] = '0;

  for (genvar i = 0; i < LEN_BITS; i++) begin : g_cell
    utv_div_cell #(
      .LEN_BITS (LEN_BITS),
      .DEN_BITS (DEN_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .rem_up   (c_rem[i]),
      .den_up   (c_den[i]),
      .low_up   (c_low[i]),
      .q_up     (c_q[i]),
      .flags_up (c_flags[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .rem_dn   (c_rem[i+1]),
      .den_dn   (c_den[i+1]),
      .low_dn   (c_low[i+1]),
      .q_dn     (c_q[i+1]),
      .flags_dn (c_flags[i+1])
    );
  end

  // last cell is the output register; zero weight wins over saturation
  assign res_valid         = c_valid[LEN_BITS];
  assign c_ready[LEN_BITS] = res_ready;
  assign zero_weight       = c_flags[LEN_BITS].zero_weight;
  assign saturated         = c_flags[LEN_BITS].saturated;

  always_comb begin
    if (c_flags[LEN_BITS].zero_weight) begin
      new_length = '0;
    end else if (c_flags[LEN_BITS].saturated) begin
      new_length = {LEN_BITS{1'b1}};
    end else begin
      new_length = c_q[LEN_BITS];
    end
  end

`ifndef SYNTH
  // zero weight and saturation are exclusive on a result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid && zero_weight |-> !saturated)
    else $error("zero_weight and saturated both set");

  // pipeline comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // input only stalls when a finished result is held back
  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    !vox_ready |-> res_valid && !res_ready)
    else $error("input stalled without output back pressure");
`endif

endmodule

@@ rtl/core/utv_front.sv @@
// weight, numerator and denominator pipeline ahead of the divider chain
module utv_front #(
  parameter int GRAD_BITS = utv_pkg::GRAD_BITS_DEF,
  parameter int LEN_BITS  = utv_pkg::LEN_BITS_DEF,
  parameter int DEN_BITS  = 2 * utv_pkg::CFG_BITS + GRAD_BITS + 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [utv_pkg::CFG_BITS-1:0]          size_x,
  input  logic [utv_pkg::CFG_BITS-1:0]          size_y,
  input  logic [utv_pkg::CFG_BITS-1:0]          size_z,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic                                  sweep_reverse,
  input  logic signed [GRAD_BITS-1:0]           grad_x,
  input  logic signed [GRAD_BITS-1:0]           grad_y,
  input  logic signed [GRAD_BITS-1:0]           grad_z,
  input  logic [LEN_BITS-1:0]                   len_x_minus,
  input  logic [LEN_BITS-1:0]                   len_x_plus,
  input  logic [LEN_BITS-1:0]                   len_y_minus,
  input  logic [LEN_BITS-1:0]                   len_y_plus,
  input  logic [LEN_BITS-1:0]                   len_z_minus,
  input  logic [LEN_BITS-1:0]                   len_z_plus,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [DEN_BITS-1:0]                   rem,
  output logic [DEN_BITS-1:0]                   den,
  output logic [LEN_BITS-1:0]                   low,
  output utv_pkg::div_flags_t                   flags
);
  import utv_pkg::*;

  localparam int COEF_BITS   = 2 * CFG_BITS;
  localparam int W_BITS      = COEF_BITS + GRAD_BITS - 1;
  localparam int WHI_BITS    = W_BITS - MUL_SPLIT;
  localparam int ABC_BITS    = 3 * CFG_BITS;
  localparam int ABC_SH_BITS = ABC_BITS + GRAD_BITS - 1;
  localparam int PROD_BITS   = W_BITS + LEN_BITS;
  localparam int PLO_BITS    = MUL_SPLIT + LEN_BITS;
  localparam int PHI_BITS    = WHI_BITS + LEN_BITS;
  localparam int NUM_BITS    = ((PROD_BITS > ABC_SH_BITS) ? PROD_BITS : ABC_SH_BITS) + 2;
  localparam int HI_BITS     = NUM_BITS - LEN_BITS;

  // handshake: a stage loads when it is empty or the stage after it moves
  logic [FRONT_STAGES-1:0] v;
  logic [FRONT_STAGES-1:0] en;

  always_comb begin
    en[FRONT_STAGES-1] = ~v[FRONT_STAGES-1] | dn_ready;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= up_valid;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // gradient magnitude and upwind neighbor choice
  logic [GRAD_BITS-1:0] gx_u, gy_u, gz_u;
  logic [GRAD_BITS-1:0] mag_x_next, mag_y_next, mag_z_next;
  logic                 pos_x, pos_y, pos_z;

  always_comb begin
    gx_u = grad_x;
    gy_u = grad_y;
    gz_u = grad_z;
    mag_x_next = gx_u[GRAD_BITS-1] ? (~gx_u + GRAD_BITS'(1)) : gx_u;
    mag_y_next = gy_u[GRAD_BITS-1] ? (~gy_u + GRAD_BITS'(1)) : gy_u;
    mag_z_next = gz_u[GRAD_BITS-1] ? (~gz_u + GRAD_BITS'(1)) : gz_u;
    pos_x = ~gx_u[GRAD_BITS-1] & (gx_u != '0);
    pos_y = ~gy_u[GRAD_BITS-1] & (gy_u != '0);
    pos_z = ~gz_u[GRAD_BITS-1] & (gz_u != '0);
  end

  // stage 1: axis coefficients, magnitudes, selected lengths
  logic [COEF_BITS-1:0] coef_x, coef_y, coef_z;
  logic [GRAD_BITS-1:0] mag_x, mag_y, mag_z;
  logic [LEN_BITS-1:0]  len1_x, len1_y, len1_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      coef_x <= COEF_BITS'(size_y) * COEF_BITS'(size_z);
      coef_y <= COEF_BITS'(size_x) * COEF_BITS'(size_z);
      coef_z <= COEF_BITS'(size_x) * COEF_BITS'(size_y);
      mag_x  <= mag_x_next;
      mag_y  <= mag_y_next;
      mag_z  <= mag_z_next;
      len1_x <= (sweep_reverse ^ pos_x) ? len_x_plus : len_x_minus;
      len1_y <= (sweep_reverse ^ pos_y) ? len_y_plus : len_y_minus;
      len1_z <= (sweep_reverse ^ pos_z) ? len_z_plus : len_z_minus;
    end
  end

  // stage 2: weights and voxel volume
  logic [W_BITS-1:0]   w_x, w_y, w_z;
  logic [ABC_BITS-1:0] abc;
  logic [LEN_BITS-1:0] len2_x, len2_y, len2_z;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w_x    <= W_BITS'(coef_x) * W_BITS'(mag_x);
      w_y    <= W_BITS'(coef_y) * W_BITS'(mag_y);
      w_z    <= W_BITS'(coef_z) * W_BITS'(mag_z);
      abc    <= ABC_BITS'(coef_z) * ABC_BITS'(size_z);
      len2_x <= len1_x;
      len2_y <= len1_y;
      len2_z <= len1_z;
    end
  end

  // stage 3: split partial products, weight sum
  logic [PLO_BITS-1:0]    plo_x, plo_y, plo_z;
  logic [PHI_BITS-1:0]    phi_x, phi_y, phi_z;
  logic [DEN_BITS-1:0]    den3;
  logic [ABC_SH_BITS-1:0] abc3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      plo_x <= PLO_BITS'(w_x[MUL_SPLIT-1:0]) * PLO_BITS'(len2_x);
      plo_y <= PLO_BITS'(w_y[MUL_SPLIT-1:0]) * PLO_BITS'(len2_y);
      plo_z <= PLO_BITS'(w_z[MUL_SPLIT-1:0]) * PLO_BITS'(len2_z);
      phi_x <= PHI_BITS'(w_x[W_BITS-1:MUL_SPLIT]) * PHI_BITS'(len2_x);
      phi_y <= PHI_BITS'(w_y[W_BITS-1:MUL_SPLIT]) * PHI_BITS'(len2_y);
      phi_z <= PHI_BITS'(w_z[W_BITS-1:MUL_SPLIT]) * PHI_BITS'(len2_z);
      den3  <= DEN_BITS'(w_x) + DEN_BITS'(w_y) + DEN_BITS'(w_z);
      abc3  <= ABC_SH_BITS'(abc) << (GRAD_BITS - 1);
    end
  end

  // stage 4: recombine the partial products
  logic [PROD_BITS-1:0]   p_x, p_y, p_z;
  logic [DEN_BITS-1:0]    den4;
  logic [ABC_SH_BITS-1:0] abc4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p_x  <= PROD_BITS'(plo_x) + (PROD_BITS'(phi_x) << MUL_SPLIT);
      p_y  <= PROD_BITS'(plo_y) + (PROD_BITS'(phi_y) << MUL_SPLIT);
      p_z  <= PROD_BITS'(plo_z) + (PROD_BITS'(phi_z) << MUL_SPLIT);
      den4 <= den3;
      abc4 <= abc3;
    end
  end

  // stage 5: numerator
  logic [NUM_BITS-1:0] num;
  logic [DEN_BITS-1:0] den5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      num  <= NUM_BITS'(abc4) + NUM_BITS'(p_x) + NUM_BITS'(p_y) + NUM_BITS'(p_z);
      den5 <= den4;
    end
  end

  // stage 6: range check and divider seed
  logic [HI_BITS-1:0] num_hi;
  logic               zero_next;

  assign num_hi    = num[NUM_BITS-1:LEN_BITS];
  assign zero_next = (den5 == '0);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rem               <= num_hi[DEN_BITS-1:0];
      den               <= den5;
      low               <= num[LEN_BITS-1:0];
      flags.zero_weight <= zero_next;
      flags.saturated   <= ~zero_next & (HI_BITS'(den5) <= num_hi);
    end
  end

endmodule

@@ rtl/core/utv_div_cell.sv @@
// one restoring-division cell: one quotient bit per item
module utv_div_cell #(
  parameter int LEN_BITS = utv_pkg::LEN_BITS_DEF,
  parameter int DEN_BITS = 2 * utv_pkg::CFG_BITS + utv_pkg::GRAD_BITS_DEF + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [DEN_BITS-1:0] rem_up,
  input  logic [DEN_BITS-1:0] den_up,
  input  logic [LEN_BITS-1:0] low_up,
  input  logic [LEN_BITS-1:0] q_up,
  input  utv_pkg::div_flags_t flags_up,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [DEN_BITS-1:0] rem_dn,
  output logic [DEN_BITS-1:0] den_dn,
  output logic [LEN_BITS-1:0] low_dn,
  output logic [LEN_BITS-1:0] q_dn,
  output utv_pkg::div_flags_t flags_dn
);
  import utv_pkg::*;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                qbit;
  logic [DEN_BITS-1:0] rem_next;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    trial    = {rem_up, low_up[LEN_BITS-1]};
    diff     = trial - {1'b0, den_up};
    qbit     = (trial >= {1'b0, den_up});
    rem_next = qbit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
  end

  assign up_ready = ~dn_valid | dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_dn   <= rem_next;
      den_dn   <= den_up;
      low_dn   <= {low_up[LEN_BITS-2:0], 1'b0};
      q_dn     <= {q_up[LEN_BITS-2:0], qbit};
      flags_dn <= flags_up;
    end
  end

`ifndef SYNTH
  // partial remainder stays below the divisor on an in-range item
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !flags_dn.zero_weight && !flags_dn.saturated |-> rem_dn < den_dn)
    else $error("remainder not below divisor");

  // a zero weight sum never reports saturation
  a_zero_not_sat: assert property (@(posedge clk) disable iff (rst)
    dn_valid && flags_dn.zero_weight |-> !flags_dn.saturated && den_dn == '0)
    else $error("zero weight flag inconsistent");
`endif

endmodule
